// ===== design/aocm_pkg.sv =====
// aocm_pkg: widths, build constants and the lane control struct for the
// accelerometer offset calibration / magnitude block. No dependencies.
package aocm_pkg;

    // build constants
    localparam int CALIB_COUNT   = 100;
    localparam int AXIS_WIDTH    = 16;
    localparam int FRACTION_BITS = 4;

    // port field widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 21;

    // derived widths
    localparam int CNT_W  = $clog2(CALIB_COUNT + 1);
    localparam int SUM_W  = AXIS_WIDTH + CNT_W;
    localparam int OFF_W  = AXIS_WIDTH + FRACTION_BITS + 1;
    localparam int D_W    = OFF_W + 1;
    localparam int MAG_W  = AXIS_WIDTH + FRACTION_BITS;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ACC_W  = SQ_W + 2;
    localparam int ROOT_W = ACC_W / 2;
    localparam int DIV_W  = SUM_W + FRACTION_BITS + 1;

    // divide by CALIB_COUNT as a multiply by ceil(2^RECIP_SH / N) and a shift;
    // exact for every dividend below 2^DIV_W
    localparam int RECIP_SH = DIV_W + $clog2(CALIB_COUNT);
    localparam int RECIP_W  = DIV_W + 1;
    localparam int PROD_W   = DIV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(CALIB_COUNT - 1)) / 64'(CALIB_COUNT));

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // per-cycle strobes from the sequencer to the three axis lanes
    typedef struct packed {
        logic sum_en;    // accumulate a calibration sample
        logic diff_en;   // capture scaled sample minus offset
        logic abs_en;    // take magnitude of the difference
        logic mul_en;    // square the magnitude
        logic div_load;  // load rounded dividend from the sum
        logic div_step;  // reciprocal multiply, capture the quotient
        logic ofs_en;    // write the signed offset from the quotient
    } lane_ctrl_t;

endpackage

// ===== design/aocm_sample_if.sv =====
// aocm_sample_if: valid/ready channel carrying one three-axis sample.
// Depends on aocm_pkg for field widths.
interface aocm_sample_if import aocm_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] x_sample;
    logic signed [IN_W-1:0] y_sample;
    logic signed [IN_W-1:0] z_sample;

    modport source (output valid, output x_sample, output y_sample, output z_sample,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                    output ready);
endinterface

// ===== design/aocm_result_if.sv =====
// aocm_result_if: valid/ready channel carrying one magnitude result.
// Depends on aocm_pkg for the field width.
interface aocm_result_if import aocm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] dynamic_magnitude;

    modport source (output valid, output dynamic_magnitude, input ready);
    modport sink   (input valid, input dynamic_magnitude, output ready);
endinterface

// ===== design/aocm_lane.sv =====
// aocm_lane: one axis lane - calibration sum, offset divider, offset removal
// and squaring. Depends on aocm_pkg.
module aocm_lane
    import aocm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  logic [IN_W-1:0]   sample,
    output logic [SQ_W-1:0]   square
);

    logic        [AXIS_WIDTH-1:0] axis;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [OFF_W-1:0]      offset_reg, offset_next;
    logic signed [D_W-1:0]        scaled, diff_reg, diff_next, diff_neg;
    logic        [MAG_W-1:0]      mag_reg, mag_next;
    logic        [SQ_W-1:0]       square_reg;
    logic        [SUM_W-1:0]      sum_abs;
    logic        [DIV_W-1:0]      div_reg, dividend;
    logic        [PROD_W-1:0]     prod;
    logic                         sign_reg;
    logic        [OFF_W-1:0]      quot_reg;

    assign axis = sample[AXIS_WIDTH-1:0];

    // calibration sum
    assign sum_next = sum_reg
                    + $signed({{(SUM_W-AXIS_WIDTH){axis[AXIS_WIDTH-1]}}, axis});

    // offset removal in fractional units
    assign scaled    = $signed({{(D_W-AXIS_WIDTH){axis[AXIS_WIDTH-1]}}, axis})
                       <<< FRACTION_BITS;
    assign diff_next = scaled - $signed({offset_reg[OFF_W-1], offset_reg});
    assign diff_neg  = -diff_reg;
    assign mag_next  = diff_reg[D_W-1] ? diff_neg[MAG_W-1:0] : diff_reg[MAG_W-1:0];

    // rounded |sum| * 2^F / N through the reciprocal
    assign sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dividend = (DIV_W'(sum_abs) << FRACTION_BITS) + DIV_W'(CALIB_COUNT / 2);
    assign prod     = PROD_W'(div_reg) * PROD_W'(RECIP_M);

    assign offset_next = sign_reg ? -$signed(quot_reg) : $signed(quot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            if (ctrl.sum_en)
            begin
                sum_reg <= sum_next;
            end
            if (ctrl.ofs_en)
            begin
                offset_reg <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.diff_en)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.abs_en)
        begin
            mag_reg <= mag_next;
        end
        if (ctrl.mul_en)
        begin
            square_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        end
        if (ctrl.div_load)
        begin
            div_reg  <= dividend;
            sign_reg <= sum_reg[SUM_W-1];
        end
        if (ctrl.div_step)
        begin
            quot_reg <= prod[RECIP_SH +: OFF_W];
        end
    end

    assign square = square_reg;

endmodule

// ===== design/aocm_merge.sv =====
// aocm_merge: merging stage - adds the three lane squares and takes the
// floor square root, two operand bits per cycle. Depends on aocm_pkg.
module aocm_merge
    import aocm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   sq_x,
    input  logic [SQ_W-1:0]   sq_y,
    input  logic [SQ_W-1:0]   sq_z,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int RW    = ROOT_W + 3;
    localparam int RCNTW = $clog2(ROOT_W);

    logic [ACC_W-1:0]  op_reg, op_sum;
    logic [RW-1:0]     rem_reg, rem_next, tmp, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RCNTW-1:0]  cnt_reg;
    logic              busy_reg;
    logic              ge;

    assign op_sum = ACC_W'(sq_x) + ACC_W'(sq_y) + ACC_W'(sq_z);

    assign tmp       = {rem_reg[RW-3:0], op_reg[ACC_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign ge        = tmp >= trial;
    assign rem_next  = ge ? tmp - trial : tmp;
    assign root_next = {root_reg[ROOT_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= RCNTW'(ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op_sum;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= op_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("root unit not busy after start");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("root unit restarted while busy");

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (root_reg == '0))
        else $error("root not cleared on start");

endmodule

// ===== design/accel_offset_calib_magnitude.sv =====
// accel_offset_calib_magnitude: top level - sequencer, three axis lanes,
// merging root stage and output register. Depends on aocm_pkg, the two
// channel interfaces, aocm_lane and aocm_merge.
//
//  channel     dir  payload                         transfer when
//  samples     in   x_sample, y_sample, z_sample     valid && ready
//  magnitudes  out  dynamic_magnitude (21b)          valid && ready
//
//  Calibration samples are summed as they are accepted; the last one adds a
//  dividend load, a reciprocal multiply and an offset write.
//  A calibrated sample goes through accept, abs, square, add, then the
//  21-step iterative root in aocm_merge, then the output register load.
//  Reset clears sums, offsets, counters and the calibrated flag.
//  A finished result waits in the output register; a new sample is accepted
//  meanwhile, and only the root-to-output load stalls if it is still full.
module accel_offset_calib_magnitude
    import aocm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    aocm_sample_if.sink   samples,
    aocm_result_if.source magnitudes
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DLOAD = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_OFS   = 8'b0000_1000,
        S_ABS   = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_ROOT  = 8'b1000_0000
    } state_t;

    localparam int CMP_W = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;

    state_t            st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              calibrated_reg, calibrated_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  sat_root;
    logic [CMP_W-1:0]  root_ext;
    logic              accept;
    logic              out_load;
    logic              merge_start;
    lane_ctrl_t        ctrl;
    logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
    logic              root_busy;
    logic [ROOT_W-1:0] root;

    assign samples.ready = (st_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;

    // lanes: one per axis, same strobes
    aocm_lane u_lane_x (.clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                        .sample(samples.x_sample), .square(sq_x));
    aocm_lane u_lane_y (.clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                        .sample(samples.y_sample), .square(sq_y));
    aocm_lane u_lane_z (.clk(clk), .rst_n(rst_n), .ctrl(ctrl),
                        .sample(samples.z_sample), .square(sq_z));

    // merge: sum of squares and root
    aocm_merge u_merge (.clk(clk), .rst_n(rst_n), .start(merge_start),
                        .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z),
                        .busy(root_busy), .root(root));

    // saturate root to the output field
    assign root_ext = CMP_W'(root);
    assign sat_root = (root_ext > CMP_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(root_ext);

    always_comb
    begin
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        calibrated_next = calibrated_reg;
        ctrl            = '0;
        merge_start     = 1'b0;
        out_load        = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!calibrated_reg)
                    begin
                        ctrl.sum_en = 1'b1;
                        cnt_next    = cnt_reg + 1'b1;
                        // last calibration sample: compute offsets
                        if (cnt_reg == CNT_W'(CALIB_COUNT - 1))
                        begin
                            st_next = S_DLOAD;
                        end
                    end
                    else
                    begin
                        ctrl.diff_en = 1'b1;
                        st_next      = S_ABS;
                    end
                end
            end
            S_DLOAD:
            begin
                ctrl.div_load = 1'b1;
                st_next       = S_DIV;
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                st_next       = S_OFS;
            end
            S_OFS:
            begin
                ctrl.ofs_en     = 1'b1;
                calibrated_next = 1'b1;
                st_next         = S_IDLE;
            end
            S_ABS:
            begin
                ctrl.abs_en = 1'b1;
                st_next     = S_MUL;
            end
            S_MUL:
            begin
                ctrl.mul_en = 1'b1;
                st_next     = S_ADD;
            end
            S_ADD:
            begin
                merge_start = 1'b1;
                st_next     = S_ROOT;
            end
            S_ROOT:
            begin
                // hand the root over once the output register is free
                if (!root_busy && (!out_valid_reg || magnitudes.ready))
                begin
                    out_load = 1'b1;
                    st_next  = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (magnitudes.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_IDLE;
            cnt_reg        <= '0;
            calibrated_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            cnt_reg        <= cnt_next;
            calibrated_reg <= calibrated_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= sat_root;
        end
    end

    assign magnitudes.valid             = out_valid_reg;
    assign magnitudes.dynamic_magnitude = out_data_reg;

    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        calibrated_reg |=> calibrated_reg)
        else $error("calibrated flag dropped");

    a_load_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> calibrated_reg)
        else $error("result produced before calibration");

    a_ready_idle_root: assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready |-> !root_busy)
        else $error("sample accepted while root unit busy");

endmodule

// ===== tb/sv/accel_offset_calib_magnitude_tb.sv =====
// accel_offset_calib_magnitude_tb: self-checking bench for the accelerometer
// offset calibration / vector magnitude block. It drives sample transfers,
// predicts every magnitude in-bench and checks them in order.
// Depends on aocm_pkg, aocm_sample_if, aocm_result_if and the block itself.
module accel_offset_calib_magnitude_tb import aocm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int TAIL_ITEMS     = 150;   // no idling once this few remain
    localparam int HOLD_AFTER     = 60;    // results seen before the long hold-off
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer at all
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } accel_sample_t;

    logic clk;
    logic rst_n;

    aocm_sample_if samples_ch ();
    aocm_result_if results_ch ();

    accel_offset_calib_magnitude uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples_ch),
        .magnitudes (results_ch)
    );

    // samples waiting to be offered, filled once before reset is released
    accel_sample_t pending [$];
    // magnitudes predicted for accepted samples, oldest first
    logic [OUT_W-1:0] expected_mags [$];

    // bench copy of the block state
    longint calib_sum [3];
    longint axis_offset [3];
    int     calib_taken;
    bit     calib_done;

    int items_total;
    int items_sent;
    int results_seen;
    int failures;

    // traffic shaping
    int tx_idle_pct;
    int rx_idle_pct;
    int tx_gap;
    int rx_gap;
    int hold_left;
    bit hold_done;
    int pace_cnt;
    int idle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Axis value as the block sees it: the low AXIS_WIDTH bits, sign extended.
    function automatic longint axis_value(logic signed [IN_W-1:0] raw);
        longint v;
        v = raw;
        v = (v <<< (64 - AXIS_WIDTH)) >>> (64 - AXIS_WIDTH);
        return v;
    endfunction

    // Offset in fractional LSB: sum * 2^F / N, nearest, halves away from zero.
    function automatic longint rounded_offset(longint s);
        longint num;
        longint q;
        num = s * (64'sd1 <<< FRACTION_BITS);
        q = ((num < 0) ? -num : num);
        q = (q + CALIB_COUNT / 2) / CALIB_COUNT;
        return (num < 0) ? -q : q;
    endfunction

    // Floor square root, built one result bit at a time from the top.
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Advance the bench state by one accepted sample; queue a magnitude once
    // calibration is over. The sample that closes calibration gives none.
    function automatic void take_sample(accel_sample_t s);
        longint a [3];
        longint d;
        longint unsigned acc;
        longint unsigned root;
        a[0] = axis_value(s.x);
        a[1] = axis_value(s.y);
        a[2] = axis_value(s.z);
        if (!calib_done)
        begin
            for (int i = 0; i < 3; i++)
                calib_sum[i] += a[i];
            calib_taken++;
            if (calib_taken >= CALIB_COUNT)
            begin
                for (int i = 0; i < 3; i++)
                    axis_offset[i] = rounded_offset(calib_sum[i]);
                calib_done = 1'b1;
            end
        end
        else
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                d = a[i] * (64'sd1 <<< FRACTION_BITS) - axis_offset[i];
                if (d < 0)
                    d = -d;
                acc += longint'(d * d);
            end
            root = floor_root(acc);
            if (root > OUT_MAX)
                root = OUT_MAX;
            expected_mags.push_back(root[OUT_W-1:0]);
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic signed [IN_W-1:0] clamp_axis(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[IN_W-1:0];
    endfunction

    function automatic void queue_sample(int x, int y, int z);
        accel_sample_t s;
        s.x = clamp_axis(x);
        s.y = clamp_axis(y);
        s.z = clamp_axis(z);
        pending.push_back(s);
    endfunction

    function automatic int idle_pick();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Main sequence: build stimulus, reset once, wait for drain, report.
    // ---------------------------------------------------------------
    initial
    begin
        int calib_mode [3];
        int bias [3];
        int center [3];
        longint mean_acc [3];
        int v [3];
        int pick;

        // every input known from time zero
        rst_n                = 1'b0;
        samples_ch.valid     = 1'b0;
        samples_ch.x_sample  = '0;
        samples_ch.y_sample  = '0;
        samples_ch.z_sample  = '0;
        results_ch.ready     = 1'b0;

        for (int i = 0; i < 3; i++)
        begin
            calib_sum[i]   = 0;
            axis_offset[i] = 0;
            mean_acc[i]    = 0;
        end
        calib_taken  = 0;
        calib_done   = 1'b0;
        items_sent   = 0;
        results_seen = 0;
        failures     = 0;
        tx_idle_pct  = 20;
        rx_idle_pct  = 20;
        tx_gap       = 0;
        rx_gap       = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        pace_cnt     = 0;
        idle_cnt     = 0;

        // Calibration block. Reset happens only once, so each run picks one
        // style per axis: pinned at the negative or positive rail, full-range
        // noise, or a realistic bias plus small noise (either sign).
        for (int i = 0; i < 3; i++)
        begin
            pick = $urandom_range(9);
            calib_mode[i] = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick < 5) ? 2 : 3;
            bias[i] = int'($urandom_range(8192)) - 4096;
        end
        for (int n = 0; n < CALIB_COUNT; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                case (calib_mode[i])
                    0:       v[i] = -32768;
                    1:       v[i] = 32767;
                    2:       v[i] = int'($urandom_range(65535)) - 32768;
                    default: v[i] = bias[i] + int'($urandom_range(128)) - 64;
                endcase
                mean_acc[i] += v[i];
            end
            queue_sample(v[0], v[1], v[2]);
        end
        // rough rest position, only used to aim samples near the offsets
        for (int i = 0; i < 3; i++)
            center[i] = int'(mean_acc[i] / CALIB_COUNT);

        // Directed: every rail combination, zero, +-1, alternating bits,
        // single-axis rails and a sample right at the rest position.
        for (int c = 0; c < 8; c++)
            queue_sample(c[0] ? 32767 : -32768, c[1] ? 32767 : -32768,
                         c[2] ? 32767 : -32768);
        queue_sample(0, 0, 0);
        queue_sample(1, 1, 1);
        queue_sample(-1, -1, -1);
        queue_sample(16'sh5555, -21846, 16'sh5555);
        queue_sample(-21846, 16'sh5555, -21846);
        queue_sample(-32768, 0, 0);
        queue_sample(0, 32767, 0);
        queue_sample(0, 0, -32768);
        queue_sample(center[0], center[1], center[2]);
        queue_sample(center[0] + 1, center[1] - 1, center[2]);

        // Random body: full-range shocks, motion around rest, near-zero
        // magnitudes and per-axis corner values.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            for (int i = 0; i < 3; i++)
            begin
                if (pick < 35)
                    v[i] = int'($urandom_range(65535)) - 32768;
                else if (pick < 70)
                    v[i] = center[i] + int'($urandom_range(600)) - 300;
                else if (pick < 85)
                    v[i] = center[i] + int'($urandom_range(6)) - 3;
                else
                begin
                    case ($urandom_range(5))
                        0:       v[i] = -32768;
                        1:       v[i] = 32767;
                        2:       v[i] = -1;
                        3:       v[i] = 0;
                        4:       v[i] = 1;
                        default: v[i] = center[i];
                    endcase
                end
            end
            queue_sample(v[0], v[1], v[2]);
        end
        items_total = pending.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (items_sent == items_total);
        wait (expected_mags.size() == 0);
        // any stray result from a late sample shows up in this window
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_mags.size() != 0)
        begin
            $error("dynamic_magnitude: %0d expected results never arrived",
                   expected_mags.size());
            failures++;
        end

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // The pace counter re-picks both idle densities so long quiet stretches and
    // heavy bursts both occur.
    always @(posedge clk)
    begin
        pace_cnt++;
        if (pace_cnt % 256 == 0)
        begin
            tx_idle_pct = idle_pick();
            rx_idle_pct = idle_pick();
        end
    end

    // ---------------------------------------------------------------
    // Driver: records each accepted transfer, then offers the next sample
    // or starts an idle burst. Valid is never withdrawn while unaccepted.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        accel_sample_t s;
        if (rst_n)
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                s.x = samples_ch.x_sample;
                s.y = samples_ch.y_sample;
                s.z = samples_ch.z_sample;
                take_sample(s);
                items_sent++;
            end
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    samples_ch.valid <= 1'b0;
                end
                else if (pending.size() == 0)
                    samples_ch.valid <= 1'b0;
                else if (pending.size() > TAIL_ITEMS &&
                         $urandom_range(99) < tx_idle_pct)
                begin
                    // burst of idle cycles of random length, this one included
                    tx_gap = $urandom_range(17);
                    samples_ch.valid <= 1'b0;
                end
                else
                begin
                    s = pending.pop_front();
                    samples_ch.x_sample <= s.x;
                    samples_ch.y_sample <= s.y;
                    samples_ch.z_sample <= s.z;
                    samples_ch.valid    <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver ready: random stall bursts plus one long hold-off so the
    // output register and root stage fill and the input stalls.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_ch.valid && results_ch.ready)
                results_seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                results_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                results_ch.ready <= 1'b0;
            end
            else if (pending.size() > TAIL_ITEMS &&
                     $urandom_range(99) < rx_idle_pct)
            begin
                rx_gap = $urandom_range(17);
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every result transfer is matched against the oldest
    // prediction.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_mags.size() == 0)
            begin
                $error("dynamic_magnitude: unexpected result, got %0d",
                       results_ch.dynamic_magnitude);
                failures++;
            end
            else
            begin
                want = expected_mags.pop_front();
                if (results_ch.dynamic_magnitude !== want)
                begin
                    $error("dynamic_magnitude: expected %0d, got %0d",
                           want, results_ch.dynamic_magnitude);
                    failures++;
                end
            end
        end
    end

    // Watchdog: ends a hung run. Longest legal quiet stretch is the
    // deliberate hold-off, well under the limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_ch.valid && samples_ch.ready) ||
                (results_ch.valid && results_ch.ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
